### src/psp_pkg.sv
`default_nettype none
package psp_pkg;
   localparam int StateW  = 6;
   localparam int ActionW = 4;
   localparam int NumStates = 1 << StateW;
   localparam int ModelAw = 2 * StateW + ActionW;
   localparam int QAw     = StateW + ActionW;
   localparam int ProbW   = 17;
   localparam int ValW    = 32;
   localparam int CountW  = 7;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 31;
   localparam int ReqDataW = 72;
   localparam int RspDataW = 72;

   localparam logic [2:0] CMD_LOAD_P = 3'd0;
   localparam logic [2:0] CMD_LOAD_R = 3'd1;
   localparam logic [2:0] CMD_UPDATE = 3'd2;
   localparam logic [2:0] CMD_SWEEP  = 3'd3;

   localparam logic [CsrIdxW-1:0] REG_DISCOUNT = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_THETA    = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_SWEEPS   = 2'd2;

   localparam logic [15:0] DISCOUNT_RESET = 16'd58982;
   localparam logic [ProbW-1:0] PROB_ONE = 17'h10000;
endpackage
`default_nettype wire

### src/prioritized_sweeping_planner.sv
`default_nettype none
// Tabular planner that keeps a transition and reward model, a Q table, a value table and a
// priority set of states. After reset the block clears its tables and accepts no item
// meanwhile. A load writes its model entry in the dispatch state, and loads and reads then
// return the result. An update streams one multiply-accumulate pipeline over the 64
// successor states, and the row maximum then scans the 16 actions. Each sweep pop scans the
// 64 priorities, probes all 1024 (state, action) pairs, and adds one update per pair with a
// nonzero transition into the popped state. Each model memory has a single read port. One
// item is in work at a time.
module prioritized_sweeping_planner (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // state_from, action, state_to, probability, reward, zero fill.
   input  wire logic [psp_pkg::ReqDataW-1:0]   req_tdata,
   // cmd.
   input  wire logic [2:0]                     req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // q_value, state_value, queue_length, zero fill.
   output logic [psp_pkg::RspDataW-1:0]        rsp_tdata,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [psp_pkg::CsrIdxW-1:0]    csr_index,
   input  wire logic [psp_pkg::CsrDataW-1:0]   csr_data
);
   localparam logic [3:0] ST_CLEAR = 4'd0,  ST_IDLE = 4'd1,  ST_DISP = 4'd2,
                          ST_UACC = 4'd3,   ST_UWQ = 4'd4,   ST_UMAX = 4'd5,
                          ST_URV = 4'd6,    ST_UWV = 4'd7,   ST_SWTOP = 4'd8,
                          ST_SWSCAN = 4'd9, ST_SWRDP = 4'd10, ST_SWCHK = 4'd11,
                          ST_SANEXT = 4'd12, ST_RES = 4'd13, ST_RESW = 4'd14;
   localparam int SW = psp_pkg::StateW;
   localparam int AW = psp_pkg::ActionW;
   localparam int MAW = psp_pkg::ModelAw;
   localparam int QAW = psp_pkg::QAw;
   localparam int NS = psp_pkg::NumStates;

   logic [psp_pkg::ProbW-1:0] prob_mem [1 << MAW];
   logic [31:0]               rew_mem [1 << MAW];
   logic [31:0]               q_mem [1 << QAW];
   logic [31:0]               val_mem [NS];
   logic [31:0]               pri_mem [NS];

   logic                      prob_we, rew_we, q_we, val_we, pri_we;
   logic [MAW-1:0]            prob_wa, prob_ra, rew_wa, rew_ra;
   logic [QAW-1:0]            q_wa, q_ra;
   logic [SW-1:0]             val_wa, val_ra, pri_wa, pri_ra;
   logic [psp_pkg::ProbW-1:0] prob_wd, prob_rd;
   logic [31:0]               rew_wd, q_wd, val_wd, pri_wd, pri_rd;
   logic signed [31:0]        rew_rd, q_rd, val_rd;

   always_ff @(posedge clock) begin
      if (prob_we) begin
         prob_mem[prob_wa] <= prob_wd;
      end
      prob_rd <= prob_mem[prob_ra];
   end
   always_ff @(posedge clock) begin
      if (rew_we) begin
         rew_mem[rew_wa] <= rew_wd;
      end
      rew_rd <= rew_mem[rew_ra];
   end
   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[q_wa] <= q_wd;
      end
      q_rd <= q_mem[q_ra];
   end
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_wa] <= val_wd;
      end
      val_rd <= val_mem[val_ra];
   end
   always_ff @(posedge clock) begin
      if (pri_we) begin
         pri_mem[pri_wa] <= pri_wd;
      end
      pri_rd <= pri_mem[pri_ra];
   end

   logic [3:0]                state_ff, state_in;
   logic [MAW-1:0]            clr_ff, clr_in;
   logic [2:0]                cmd_ff, cmd_in;
   logic [SW-1:0]             s_ff, s_in, s1_ff, s1_in, top_ff, top_in, sidx_ff, sidx_in;
   logic [AW-1:0]             a_ff, a_in;
   logic [psp_pkg::ProbW-1:0] p_ff, p_in;
   logic [31:0]               r_ff, r_in;
   logic [QAW-1:0]            sa_ff, sa_in;
   logic [6:0]                k_ff, k_in;
   logic [3:0]                vld_ff, vld_in;
   logic                      mvld_ff, mvld_in, svld_ff, svld_in, found_ff, found_in;
   logic signed [41:0]        acc_ff, acc_in;
   logic signed [31:0]        best_ff, best_in;
   logic [31:0]               best_pri_ff, best_pri_in;
   logic [9:0]                pops_ff, pops_in;
   logic [psp_pkg::CountW-1:0] count_ff, count_in;
   logic [NS-1:0]             member_ff, member_in;
   logic [15:0]               discount_ff;
   logic [30:0]               theta_ff;
   logic [9:0]                spb_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [psp_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;

   logic signed [48:0] prod1_ff;
   logic signed [48:0] rnd1;
   logic [psp_pkg::ProbW-1:0] p1_ff, p2_ff;
   logic signed [31:0] r1_ff;
   logic signed [33:0] t_ff;
   logic signed [51:0] prod2_ff;
   logic signed [51:0] rnd2;
   logic signed [41:0] acc_sum;
   logic signed [31:0] q_sat;
   logic signed [32:0] vdiff;
   logic [32:0]        vabs;
   logic [31:0]        change;
   logic [psp_pkg::ProbW-1:0] req_prob;

   always_ff @(posedge clock) begin
      prod1_ff <= $signed({1'b0, discount_ff}) * val_rd;
      p1_ff    <= prob_rd;
      r1_ff    <= rew_rd;
      t_ff     <= {{2{r1_ff[31]}}, r1_ff} + {rnd1[48], rnd1[48:16]};
      p2_ff    <= p1_ff;
      prod2_ff <= $signed({1'b0, p2_ff}) * t_ff;
   end

   assign rnd1 = prod1_ff + 49'sd32768;
   assign rnd2 = prod2_ff + 52'sd32768;
   assign acc_sum = acc_ff + {{6{rnd2[51]}}, rnd2[51:16]};

   always_comb begin
      if (!acc_ff[41] && (|acc_ff[40:31])) begin
         q_sat = 32'sh7fffffff;
      end else if (acc_ff[41] && !(&acc_ff[40:31])) begin
         q_sat = 32'sh80000000;
      end else begin
         q_sat = acc_ff[31:0];
      end
   end

   assign vdiff  = {best_ff[31], best_ff} - {val_rd[31], val_rd};
   assign vabs   = vdiff[32] ? 33'(-vdiff) : vdiff;
   assign change = vabs[31:0];
   assign req_prob = (req_tdata[32] && (|req_tdata[31:16])) ? psp_pkg::PROB_ONE
                                                              : req_tdata[32:16];

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cmd_in = cmd_ff;
      s_in = s_ff;
      s1_in = s1_ff;
      a_in = a_ff;
      p_in = p_ff;
      r_in = r_ff;
      top_in = top_ff;
      sidx_in = sidx_ff;
      sa_in = sa_ff;
      k_in = k_ff;
      vld_in = {vld_ff[2:0], 1'b0};
      mvld_in = 1'b0;
      svld_in = 1'b0;
      found_in = found_ff;
      acc_in = acc_ff;
      best_in = best_ff;
      best_pri_in = best_pri_ff;
      pops_in = pops_ff;
      count_in = count_ff;
      member_in = member_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      prob_we = 1'b0;
      rew_we = 1'b0;
      q_we = 1'b0;
      val_we = 1'b0;
      pri_we = 1'b0;
      prob_wa = {s_ff, a_ff, s1_ff};
      rew_wa = {s_ff, a_ff, s1_ff};
      prob_wd = p_ff;
      rew_wd = r_ff;
      q_wa = sa_ff;
      q_wd = q_sat;
      val_wa = sa_ff[QAW-1:AW];
      val_wd = best_ff;
      pri_wa = sa_ff[QAW-1:AW];
      pri_wd = change;
      prob_ra = {sa_ff, k_ff[SW-1:0]};
      rew_ra = {sa_ff, k_ff[SW-1:0]};
      val_ra = k_ff[SW-1:0];
      q_ra = {s_ff, a_ff};
      pri_ra = k_ff[SW-1:0];
      if (vld_ff[3]) begin
         acc_in = acc_sum;
      end
      case (state_ff)
         ST_CLEAR: begin
            prob_we = 1'b1;
            rew_we = 1'b1;
            prob_wa = clr_ff;
            rew_wa = clr_ff;
            prob_wd = '0;
            rew_wd = '0;
            q_we = ~|clr_ff[MAW-1:QAW];
            q_wa = clr_ff[QAW-1:0];
            q_wd = '0;
            val_we = ~|clr_ff[MAW-1:SW];
            pri_we = ~|clr_ff[MAW-1:SW];
            val_wa = clr_ff[SW-1:0];
            pri_wa = clr_ff[SW-1:0];
            val_wd = '0;
            pri_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tuser;
               s_in = req_tdata[5:0];
               a_in = req_tdata[9:6];
               s1_in = req_tdata[15:10];
               p_in = req_prob;
               r_in = req_tdata[64:33];
               state_in = ST_DISP;
            end
         end
         ST_DISP: begin
            state_in = ST_RES;
            case (cmd_ff)
               psp_pkg::CMD_LOAD_P: prob_we = 1'b1;
               psp_pkg::CMD_LOAD_R: rew_we = 1'b1;
               psp_pkg::CMD_UPDATE: begin
                  sa_in = {s_ff, a_ff};
                  k_in = '0;
                  acc_in = '0;
                  vld_in = '0;
                  state_in = ST_UACC;
               end
               psp_pkg::CMD_SWEEP: begin
                  pops_in = '0;
                  state_in = ST_SWTOP;
               end
               default: state_in = ST_RES;
            endcase
         end
         ST_UACC: begin
            if (!k_ff[6]) begin
               vld_in[0] = 1'b1;
               k_in = k_ff + 1'b1;
            end else if (vld_ff == '0) begin
               state_in = ST_UWQ;
            end
         end
         ST_UWQ: begin
            q_we = 1'b1;
            k_in = '0;
            found_in = 1'b0;
            state_in = ST_UMAX;
         end
         ST_UMAX: begin
            q_ra = {sa_ff[QAW-1:AW], k_ff[AW-1:0]};
            if (k_ff[AW] == 1'b0) begin
               mvld_in = 1'b1;
               k_in = k_ff + 1'b1;
            end
            if (mvld_ff && (!found_ff || q_rd > best_ff)) begin
               best_in = q_rd;
               found_in = 1'b1;
            end
            if (k_ff[AW] && !mvld_ff) begin
               state_in = ST_URV;
            end
         end
         ST_URV: begin
            val_ra = sa_ff[QAW-1:AW];
            pri_ra = sa_ff[QAW-1:AW];
            state_in = ST_UWV;
         end
         ST_UWV: begin
            val_we = 1'b1;
            if (change > {1'b0, theta_ff}) begin
               if (member_ff[sa_ff[QAW-1:AW]]) begin
                  pri_we = pri_rd < change;
               end else begin
                  pri_we = 1'b1;
                  member_in[sa_ff[QAW-1:AW]] = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            state_in = (cmd_ff == psp_pkg::CMD_SWEEP) ? ST_SANEXT : ST_RES;
         end
         ST_SWTOP: begin
            k_in = '0;
            found_in = 1'b0;
            state_in = (pops_ff == spb_ff) ? ST_RES : ST_SWSCAN;
         end
         ST_SWSCAN: begin
            if (!k_ff[6]) begin
               svld_in = 1'b1;
               sidx_in = k_ff[SW-1:0];
               k_in = k_ff + 1'b1;
            end
            if (svld_ff && member_ff[sidx_ff] && (!found_ff || pri_rd > best_pri_ff)) begin
               top_in = sidx_ff;
               best_pri_in = pri_rd;
               found_in = 1'b1;
            end
            if (k_ff[6] && !svld_ff) begin
               if (!found_ff) begin
                  state_in = ST_RES;
               end else begin
                  pri_we = 1'b1;
                  pri_wa = top_ff;
                  pri_wd = '0;
                  member_in[top_ff] = 1'b0;
                  count_in = count_ff - 1'b1;
                  pops_in = pops_ff + 1'b1;
                  sa_in = '0;
                  state_in = ST_SWRDP;
               end
            end
         end
         ST_SWRDP: begin
            prob_ra = {sa_ff, top_ff};
            state_in = ST_SWCHK;
         end
         ST_SWCHK: begin
            if (prob_rd != '0) begin
               k_in = '0;
               acc_in = '0;
               vld_in = '0;
               state_in = ST_UACC;
            end else begin
               state_in = ST_SANEXT;
            end
         end
         ST_SANEXT: begin
            sa_in = sa_ff + 1'b1;
            state_in = (&sa_ff) ? ST_SWTOP : ST_SWRDP;
         end
         ST_RES: begin
            val_ra = s_ff;
            state_in = ST_RESW;
         end
         ST_RESW: begin
            val_ra = s_ff;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {1'b0, count_ff, val_rd, q_rd};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         vld_ff <= '0;
         mvld_ff <= 1'b0;
         svld_ff <= 1'b0;
         member_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         discount_ff <= psp_pkg::DISCOUNT_RESET;
         theta_ff <= '0;
         spb_ff <= 10'd1;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         vld_ff <= vld_in;
         mvld_ff <= mvld_in;
         svld_ff <= svld_in;
         member_ff <= member_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               psp_pkg::REG_DISCOUNT: discount_ff <= csr_data[15:0];
               psp_pkg::REG_THETA:    theta_ff <= csr_data;
               psp_pkg::REG_SWEEPS:   spb_ff <= csr_data[9:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      s_ff <= s_in;
      s1_ff <= s1_in;
      a_ff <= a_in;
      p_ff <= p_in;
      r_ff <= r_in;
      top_ff <= top_in;
      sidx_ff <= sidx_in;
      sa_ff <= sa_in;
      k_ff <= k_in;
      found_ff <= found_in;
      acc_ff <= acc_in;
      best_ff <= best_in;
      best_pri_ff <= best_pri_in;
      pops_ff <= pops_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;
endmodule
`default_nettype wire

### src/psp_checker.sv
`default_nettype none
module psp_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [psp_pkg::RspDataW-1:0]  rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("block active right after reset");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");
   a_qlen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[70:64] <= 7'd64)
      else $error("queue length beyond the state count");
endmodule

bind prioritized_sweeping_planner psp_checker u_psp_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_READ = 3'd4;
   localparam logic [2:0] CMD_LAST = 3'd7;
   localparam int CycleLimit = 8000000;
   localparam int RandomPerPhase = 435;
   localparam int HoldCycles = 3000;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [5:0]  s;
      logic [3:0]  a;
      logic [5:0]  s1;
      logic [16:0] p;
      logic [31:0] r;
   } plan_cmd_type;

   typedef struct {
      int          q;
      int          v;
      bit [6:0]    n;
   } plan_result_type;

   class plan_tracker_type;
      bit [16:0]   prob_tbl[65536];
      int          rew_tbl[65536];
      int          q_tbl[1024];
      int          v_tbl[64];
      int unsigned prio[64];
      bit          queued[64];
      int unsigned queue_count;
      bit [15:0]   discount = psp_pkg::DISCOUNT_RESET;
      bit [30:0]   theta;
      bit [9:0]    pops_per_sweep = 10'd1;
      plan_result_type pending_results[$];
      int          errors;
      int          checked;
      int          sweeps_seen;

      function longint round16(longint x);
         return (x + 64'sd32768) >>> 16;
      endfunction

      function void write_reg(logic [psp_pkg::CsrIdxW-1:0] idx,
                              logic [psp_pkg::CsrDataW-1:0] val);
         case (idx)
            psp_pkg::REG_DISCOUNT: discount = val[15:0];
            psp_pkg::REG_THETA:    theta = val[30:0];
            psp_pkg::REG_SWEEPS:   pops_per_sweep = val[9:0];
            default: ;
         endcase
      endfunction

      function void refresh_q(int s, int a);
         longint acc, d, t, diff;
         int idx, best, old_v;
         int unsigned change;
         acc = 0;
         for (int s1 = 0; s1 < 64; s1++) begin
            idx = (s * 16 + a) * 64 + s1;
            if (prob_tbl[idx] != 0) begin
               d = round16(longint'(discount) * longint'(v_tbl[s1]));
               t = longint'(rew_tbl[idx]) + d;
               acc += round16(longint'(prob_tbl[idx]) * t);
            end
         end
         if (acc > 64'sd2147483647) q_tbl[s * 16 + a] = 32'h7fffffff;
         else if (acc < -64'sd2147483648) q_tbl[s * 16 + a] = 32'h80000000;
         else q_tbl[s * 16 + a] = int'(acc);
         old_v = v_tbl[s];
         best = q_tbl[s * 16];
         for (int k = 1; k < 16; k++)
            if (q_tbl[s * 16 + k] > best) best = q_tbl[s * 16 + k];
         v_tbl[s] = best;
         diff = longint'(best) - longint'(old_v);
         if (diff < 0) diff = -diff;
         change = diff[31:0];
         if (change > theta) begin
            if (queued[s]) begin
               if (prio[s] < change) prio[s] = change;
            end else begin
               queued[s] = 1'b1;
               prio[s] = change;
               queue_count++;
            end
         end
      endfunction

      function void run_sweep();
         int top;
         for (int i = 0; i < pops_per_sweep; i++) begin
            top = -1;
            for (int k = 0; k < 64; k++)
               if (queued[k] && (top < 0 || prio[k] > prio[top])) top = k;
            if (top < 0) return;
            queued[top] = 1'b0;
            prio[top] = 0;
            queue_count--;
            for (int s = 0; s < 64; s++)
               for (int a = 0; a < 16; a++)
                  if (prob_tbl[(s * 16 + a) * 64 + top] != 0) refresh_q(s, a);
         end
      endfunction

      function void note_command(plan_cmd_type it);
         int idx;
         plan_result_type res;
         bit [16:0] p;
         idx = (int'(it.s) * 16 + int'(it.a)) * 64 + int'(it.s1);
         p = (it.p > psp_pkg::PROB_ONE) ? psp_pkg::PROB_ONE : it.p;
         case (it.cmd)
            psp_pkg::CMD_LOAD_P: prob_tbl[idx] = p;
            psp_pkg::CMD_LOAD_R: rew_tbl[idx] = it.r;
            psp_pkg::CMD_UPDATE: refresh_q(it.s, it.a);
            psp_pkg::CMD_SWEEP: begin
               run_sweep();
               sweeps_seen++;
            end
            default: ;
         endcase
         res.q = q_tbl[int'(it.s) * 16 + int'(it.a)];
         res.v = v_tbl[it.s];
         res.n = queue_count[6:0];
         pending_results.push_back(res);
      endfunction

      task report(string what, longint got, longint want);
         errors++;
         $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                  what, got, want, checked);
      endtask

      task check_result(logic [psp_pkg::RspDataW-1:0] data);
         plan_result_type want;
         checked++;
         if (pending_results.size() == 0) begin
            report("unexpected result", 0, 0);
            return;
         end
         want = pending_results.pop_front();
         if (data[31:0] !== want.q) report("q_value", int'(data[31:0]), want.q);
         if (data[63:32] !== want.v) report("state_value", int'(data[63:32]), want.v);
         if (data[70:64] !== want.n) report("queue_length", data[70:64], want.n);
      endtask
   endclass

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [psp_pkg::ReqDataW-1:0] req_tdata;
   logic [2:0] req_tuser;
   logic rsp_tvalid, rsp_tready;
   logic [psp_pkg::RspDataW-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [psp_pkg::CsrIdxW-1:0] csr_index;
   logic [psp_pkg::CsrDataW-1:0] csr_data;

   plan_tracker_type tracker = new();
   int send_idle_pct, recv_stall_pct;
   bit hold_rsp;
   int cycles;

   prioritized_sweeping_planner dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(negedge clock)
      rsp_tready <= !hold_rsp && !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata);

   task automatic send_cmd(plan_cmd_type it);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= it.cmd;
      req_tdata <= {7'b0, it.r, it.p, it.s1, it.a, it.s};
      do @(posedge clock); while (!req_tready);
      tracker.note_command(it);
   endtask

   task automatic write_csr(logic [psp_pkg::CsrIdxW-1:0] idx,
                            logic [psp_pkg::CsrDataW-1:0] val);
      @(negedge clock);
      req_tvalid <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic plan_cmd_type make_cmd(logic [2:0] cmd, int s, int a, int s1,
                                             int p, logic [31:0] r);
      plan_cmd_type it;
      it.cmd = cmd;
      it.s = 6'(s);
      it.a = 4'(a);
      it.s1 = 6'(s1);
      it.p = 17'(p);
      it.r = r;
      return it;
   endfunction

   // Most items stay within a few states and actions so that updates and sweeps
   // interact; the rest spread over the whole index range.
   function automatic plan_cmd_type random_cmd();
      plan_cmd_type it;
      int pick;
      bit narrow;
      narrow = $urandom_range(99) < 85;
      it.s = 6'(narrow ? $urandom_range(7) : $urandom_range(63));
      it.a = 4'(narrow ? $urandom_range(3) : $urandom_range(15));
      it.s1 = 6'(narrow ? $urandom_range(7) : $urandom_range(63));
      pick = $urandom_range(99);
      it.p = pick < 10 ? 17'd0 : pick < 20 ? psp_pkg::PROB_ONE
             : pick < 27 ? 17'($urandom_range(131071)) : 17'($urandom_range(65536));
      pick = $urandom_range(99);
      it.r = pick < 15 ? $urandom()
             : 32'($signed($urandom_range(2 * 65536 * 40)) - 65536 * 40);
      pick = $urandom_range(99);
      it.cmd = pick < 30 ? psp_pkg::CMD_LOAD_P : pick < 52 ? psp_pkg::CMD_LOAD_R
               : pick < 82 ? psp_pkg::CMD_UPDATE
               : pick < 84 ? psp_pkg::CMD_SWEEP : pick < 95 ? CMD_READ
               : 3'($urandom_range(int'(CMD_READ) + 1, int'(CMD_LAST)));
      return it;
   endfunction

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_csr(psp_pkg::REG_DISCOUNT, 31'd65535);
      write_csr(psp_pkg::REG_THETA, 31'h7fffffff);
      write_csr(psp_pkg::REG_SWEEPS, 31'd1023);
      send_cmd(make_cmd(psp_pkg::CMD_LOAD_P, 63, 15, 63, 131071, '0));
      send_cmd(make_cmd(psp_pkg::CMD_LOAD_R, 63, 15, 63, 0, 32'h7fffffff));
      send_cmd(make_cmd(psp_pkg::CMD_LOAD_P, 63, 15, 0, 65536, '0));
      send_cmd(make_cmd(psp_pkg::CMD_LOAD_R, 63, 15, 0, 0, 32'h7fffffff));
      send_cmd(make_cmd(psp_pkg::CMD_UPDATE, 63, 15, 0, 0, '0));
      send_cmd(make_cmd(CMD_READ, 63, 15, 0, 0, '0));
      send_cmd(make_cmd(psp_pkg::CMD_LOAD_R, 63, 15, 63, 0, 32'h80000000));
      send_cmd(make_cmd(psp_pkg::CMD_LOAD_R, 63, 15, 0, 0, 32'h80000000));
      send_cmd(make_cmd(psp_pkg::CMD_UPDATE, 63, 15, 0, 0, '0));
      send_cmd(make_cmd(psp_pkg::CMD_SWEEP, 63, 15, 0, 0, '0));
      send_cmd(make_cmd(psp_pkg::CMD_LOAD_P, 63, 15, 0, 0, '0));
      send_cmd(make_cmd(psp_pkg::CMD_LOAD_P, 0, 0, 0, 1, '0));
      send_cmd(make_cmd(psp_pkg::CMD_LOAD_R, 0, 0, 0, 0, 32'hffffffff));
      send_cmd(make_cmd(psp_pkg::CMD_UPDATE, 0, 0, 0, 0, '0));
      send_cmd(make_cmd(3'd5, 0, 0, 0, 0, '0));
      send_cmd(make_cmd(3'd6, 63, 15, 63, 65536, 32'h7fffffff));
      send_cmd(make_cmd(CMD_LAST, 1, 2, 3, 4, '0));
      send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, '0));
      send_cmd(make_cmd(psp_pkg::CMD_SWEEP, 0, 0, 0, 0, '0));
      send_cmd(make_cmd(psp_pkg::CMD_UPDATE, 63, 15, 0, 0, '0));

      for (int ph = 0; ph < 4; ph++) begin
         wait_drained();
         case (ph)
            0: begin
               write_csr(psp_pkg::REG_DISCOUNT, 31'd0);
               write_csr(psp_pkg::REG_THETA, 31'd0);
               write_csr(psp_pkg::REG_SWEEPS, 31'd2);
            end
            1: begin
               write_csr(psp_pkg::REG_DISCOUNT, 31'(psp_pkg::DISCOUNT_RESET));
               write_csr(psp_pkg::REG_THETA, 31'h100);
               write_csr(psp_pkg::REG_SWEEPS, 31'd1);
            end
            2: begin
               write_csr(psp_pkg::REG_DISCOUNT, 31'd32768);
               write_csr(psp_pkg::REG_THETA, 31'd0);
               write_csr(psp_pkg::REG_SWEEPS, 31'd0);
            end
            default: begin
               write_csr(psp_pkg::REG_DISCOUNT, 31'd65535);
               write_csr(psp_pkg::REG_SWEEPS, 31'd3);
            end
         endcase
         send_idle_pct = (ph == 1) ? 81 : (ph == 3) ? 32 : 0;
         recv_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 32 : 0;
         if (ph == 0)
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (HoldCycles) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         for (int i = 0; i < RandomPerPhase; i++) begin
            if (ph == 1 && i == RandomPerPhase / 2) wait_drained();
            send_cmd(random_cmd());
         end
         @(negedge clock);
         req_tvalid <= 1'b0;
      end

      wait_drained();
      repeat (200) @(posedge clock);
      $display("Checked %0d results over loads, updates, %0d sweeps, reads and unknown codes,",
               tracker.checked, tracker.sweeps_seen);
      $display("with four register settings and idle, stall and back-pressure phases.");
      if (tracker.errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire

### files.f
src/psp_pkg.sv
src/prioritized_sweeping_planner.sv
src/psp_checker.sv
tb/testbench.sv
